FILE: rtl/mdcc_pkg.sv
package mdcc_pkg;

  localparam int unsigned WheelCount    = 4;
  localparam int unsigned DirWidth      = 2;
  localparam int unsigned MoveWidth     = 5;
  localparam int unsigned SpeedWidth    = 8;
  localparam int unsigned DurWidth      = 16;
  localparam int unsigned SpeedReqWidth = 16;
  localparam int unsigned DurReqWidth   = 17;
  localparam int unsigned TableSize     = 19;

  typedef logic [DirWidth-1:0] dir_t;
  typedef logic [WheelCount-1:0][DirWidth-1:0] wheels_t;

  localparam dir_t DirRel = 2'd0;
  localparam dir_t DirFwd = 2'd1;
  localparam dir_t DirBwd = 2'd2;

  localparam logic [MoveWidth-1:0] MoveStop   = 5'd0;
  localparam logic [MoveWidth-1:0] MoveResume = 5'd19;

  // register indexes on the config port
  localparam logic [1:0] RegMaxSpeed  = 2'd0;
  localparam logic [1:0] RegMaxDur    = 2'd1;
  localparam logic [1:0] RegTimeout   = 2'd2;

  localparam logic [SpeedWidth-1:0] MaxSpeedRst = 8'd255;
  localparam logic [DurWidth-1:0]   MaxDurRst   = 16'd10000;
  localparam logic [DurWidth-1:0]   TimeoutRst  = 16'd1000;

  // wheel order from index 0: front left, front right, rear right, rear left
  function automatic wheels_t move_dirs(logic [MoveWidth-1:0] code);
    wheels_t w;
    w = '{DirRel, DirRel, DirRel, DirRel};
    case (code)
      5'd1:    w = '{DirFwd, DirFwd, DirFwd, DirFwd};
      5'd2:    w = '{DirBwd, DirBwd, DirBwd, DirBwd};
      5'd3:    w = '{DirBwd, DirFwd, DirBwd, DirFwd};
      5'd4:    w = '{DirFwd, DirBwd, DirFwd, DirBwd};
      5'd5:    w = '{DirRel, DirFwd, DirRel, DirFwd};
      5'd6:    w = '{DirFwd, DirRel, DirFwd, DirRel};
      5'd7:    w = '{DirRel, DirBwd, DirRel, DirBwd};
      5'd8:    w = '{DirBwd, DirRel, DirBwd, DirRel};
      5'd9:    w = '{DirRel, DirBwd, DirBwd, DirRel};
      5'd10:   w = '{DirRel, DirFwd, DirFwd, DirRel};
      5'd11:   w = '{DirBwd, DirRel, DirRel, DirBwd};
      5'd12:   w = '{DirFwd, DirRel, DirRel, DirFwd};
      5'd13:   w = '{DirRel, DirRel, DirBwd, DirFwd};
      5'd14:   w = '{DirFwd, DirBwd, DirRel, DirRel};
      5'd15:   w = '{DirBwd, DirRel, DirFwd, DirRel};
      5'd16:   w = '{DirRel, DirBwd, DirRel, DirFwd};
      5'd17:   w = '{DirFwd, DirBwd, DirBwd, DirFwd};
      5'd18:   w = '{DirBwd, DirFwd, DirFwd, DirBwd};
      default: w = '{DirRel, DirRel, DirRel, DirRel};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/mecanum_drive_command_controller.sv
// an accepted input transaction's result reaches the master side in the next cycle
// throughput: one item per cycle without back-pressure; the output refills as it drains
// reset: asynchronous, active low; manual mode, wheels released, speed and move time zero,
//   clamp limits 255 and 10000 ms, timeout 1000 ms, output register empty
module mecanum_drive_command_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // move_code[4:0], speed_request[20:5],
                                     // duration_request[37:21], zero pad
  input  logic        s_axis_tuser,  // cmd: 0 move command, 1 tick
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // dir_front_left[1:0], dir_front_right[3:2],
                                     // dir_rear_right[5:4], dir_rear_left[7:6],
                                     // drive_speed[15:8], moving[16], autonomous[17],
                                     // reported_move[22:18], zero pad
);

  // config registers
  logic [mdcc_pkg::SpeedWidth-1:0] max_speed_q;
  logic [mdcc_pkg::DurWidth-1:0]   max_dur_q;
  logic [mdcc_pkg::DurWidth-1:0]   timeout_q;

  // block state
  logic                             mode_q, mode_d;
  logic [mdcc_pkg::DurWidth-1:0]    remain_q, remain_d;
  logic [mdcc_pkg::DurWidth-1:0]    idle_q, idle_d;
  mdcc_pkg::wheels_t                wheels_q, wheels_d;
  logic [mdcc_pkg::SpeedWidth-1:0]  speed_q, speed_d;
  logic [mdcc_pkg::MoveWidth-1:0]   last_q, last_d;

  logic        out_valid_q;
  logic [23:0] out_data_q, out_data_d;

  logic                                 in_fire;
  logic [mdcc_pkg::MoveWidth-1:0]       code;
  logic [mdcc_pkg::SpeedReqWidth-1:0]   sp_req;
  logic [mdcc_pkg::DurReqWidth-1:0]     du_req;
  logic [mdcc_pkg::SpeedWidth-1:0]      sp_clamp;
  logic [mdcc_pkg::DurWidth-1:0]        du_clamp;
  logic [mdcc_pkg::DurWidth-1:0]        remain_dec;
  logic [mdcc_pkg::DurWidth-1:0]        idle_inc;
  logic                                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      mdcc_pkg::RegMaxSpeed: prdata = {24'd0, max_speed_q};
      mdcc_pkg::RegMaxDur:   prdata = {16'd0, max_dur_q};
      mdcc_pkg::RegTimeout:  prdata = {16'd0, timeout_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= mdcc_pkg::MaxSpeedRst;
      max_dur_q   <= mdcc_pkg::MaxDurRst;
      timeout_q   <= mdcc_pkg::TimeoutRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mdcc_pkg::RegMaxSpeed: max_speed_q <= pwdata[mdcc_pkg::SpeedWidth-1:0];
        mdcc_pkg::RegMaxDur:   max_dur_q   <= pwdata[mdcc_pkg::DurWidth-1:0];
        mdcc_pkg::RegTimeout:  timeout_q   <= pwdata[mdcc_pkg::DurWidth-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  assign code   = s_axis_tdata[4:0];
  assign sp_req = s_axis_tdata[20:5];
  assign du_req = s_axis_tdata[37:21];

  // negative requests clamp to zero, large ones to the configured limit
  always_comb begin
    if (sp_req[mdcc_pkg::SpeedReqWidth-1]) begin
      sp_clamp = '0;
    end else if (sp_req > {8'd0, max_speed_q}) begin
      sp_clamp = max_speed_q;
    end else begin
      sp_clamp = sp_req[mdcc_pkg::SpeedWidth-1:0];
    end
    if (du_req[mdcc_pkg::DurReqWidth-1]) begin
      du_clamp = '0;
    end else if (du_req > {1'b0, max_dur_q}) begin
      du_clamp = max_dur_q;
    end else begin
      du_clamp = du_req[mdcc_pkg::DurWidth-1:0];
    end
  end

  assign remain_dec = (remain_q != '0) ? remain_q - 16'd1 : '0;
  assign idle_inc   = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;

  always_comb begin
    mode_d   = mode_q;
    remain_d = remain_q;
    idle_d   = idle_q;
    wheels_d = wheels_q;
    speed_d  = speed_q;
    last_d   = last_q;
    if (!s_axis_tuser) begin
      idle_d = '0;
      if (code == mdcc_pkg::MoveResume) begin
        if (!mode_q) begin
          mode_d   = 1'b1;
          last_d   = mdcc_pkg::MoveStop;
          wheels_d = '0;
          speed_d  = '0;
          remain_d = '0;
        end
      end else begin
        // a move command always leaves autonomous mode; the move below overrides everything
        mode_d = 1'b0;
        if (code >= 5'(mdcc_pkg::TableSize)) begin
          last_d   = mdcc_pkg::MoveStop;
          wheels_d = '0;
          speed_d  = '0;
          remain_d = '0;
        end else begin
          last_d = code;
          if (code == mdcc_pkg::MoveStop || sp_clamp == '0 || du_clamp == '0) begin
            wheels_d = '0;
            speed_d  = '0;
            remain_d = '0;
          end else begin
            wheels_d = mdcc_pkg::move_dirs(code);
            speed_d  = sp_clamp;
            remain_d = du_clamp;
          end
        end
      end
    end else begin
      remain_d = remain_dec;
      idle_d   = idle_inc;
      // move ended, or manual deadman expired with a move still running
      if ((remain_q != '0 && remain_dec == '0) ||
          (!mode_q && idle_inc > timeout_q && remain_dec != '0)) begin
        wheels_d = '0;
        speed_d  = '0;
        remain_d = '0;
      end
    end
  end

  always_comb begin
    out_data_d        = '0;
    out_data_d[1:0]   = wheels_d[0];
    out_data_d[3:2]   = wheels_d[1];
    out_data_d[5:4]   = wheels_d[2];
    out_data_d[7:6]   = wheels_d[3];
    out_data_d[15:8]  = speed_d;
    out_data_d[16]    = (remain_d != '0);
    out_data_d[17]    = mode_d;
    out_data_d[22:18] = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      remain_q <= '0;
      idle_q   <= '0;
      wheels_q <= '0;
      speed_q  <= '0;
      last_q   <= mdcc_pkg::MoveStop;
    end else if (in_fire) begin
      mode_q   <= mode_d;
      remain_q <= remain_d;
      idle_q   <= idle_d;
      wheels_q <= wheels_d;
      speed_q  <= speed_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 250;
  localparam int HoldPhase     = 3;
  localparam int HoldCycles    = 300;
  localparam int DrainLimit    = 2000;

  localparam logic [1:0] RegUnused = 2'd3;

  localparam logic [mdcc_pkg::MoveWidth-1:0] MoveForward   = 5'd1;
  localparam logic [mdcc_pkg::MoveWidth-1:0] MoveBackward  = 5'd2;
  localparam logic [mdcc_pkg::MoveWidth-1:0] MoveTurnRight = 5'd3;
  localparam logic [mdcc_pkg::MoveWidth-1:0] MoveTurnLeft  = 5'd4;
  localparam logic [mdcc_pkg::MoveWidth-1:0] MoveLast      = 5'(mdcc_pkg::TableSize - 1);
  localparam logic [mdcc_pkg::MoveWidth-1:0] MoveUnknownLo = 5'(mdcc_pkg::TableSize + 1);
  localparam logic [mdcc_pkg::MoveWidth-1:0] MoveUnknownHi = 5'd31;

  typedef struct packed {
    logic [4:0]     reported_move;
    logic           autonomous;
    logic           moving;
    logic [7:0]     drive_speed;
    mdcc_pkg::dir_t rear_left;
    mdcc_pkg::dir_t rear_right;
    mdcc_pkg::dir_t front_right;
    mdcc_pkg::dir_t front_left;
  } drive_status_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // move_code, speed_request, duration_request, pad
  logic        s_axis_tuser  = 1'b0;  // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // four wheel dirs, drive_speed, moving, autonomous,
                              // reported_move, pad

  bit tx_steady = 1'b0;
  int holds_asked = 0;

  int unsigned phase_speed   [NumPhases] = '{0, 255, 1, 200, 128, 255, 37, 255};
  int unsigned phase_dur     [NumPhases] = '{0, 65535, 1, 12, 30, 5, 25, 10000};
  int unsigned phase_timeout [NumPhases] = '{0, 65535, 0, 3, 10, 65535, 6, 1000};

  mecanum_drive_command_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  class drive_scoreboard;
    logic [7:0]     max_speed;
    logic [15:0]    max_dur_ms;
    logic [15:0]    timeout_ms;
    bit             auto_mode;
    logic [15:0]    remaining_ms;
    logic [15:0]    idle_ms;
    mdcc_pkg::dir_t dirs [mdcc_pkg::WheelCount];
    logic [7:0]     speed_held;
    logic [4:0]     last_code;
    mdcc_pkg::dir_t wheel_map [mdcc_pkg::TableSize][mdcc_pkg::WheelCount];
    drive_status_t  status_q [$];
    int             errors;
    int             results_seen;

    function new();
      // wheel order: front left, front right, rear right, rear left
      wheel_map = '{
        '{mdcc_pkg::DirRel, mdcc_pkg::DirRel, mdcc_pkg::DirRel, mdcc_pkg::DirRel},
        '{mdcc_pkg::DirFwd, mdcc_pkg::DirFwd, mdcc_pkg::DirFwd, mdcc_pkg::DirFwd},
        '{mdcc_pkg::DirBwd, mdcc_pkg::DirBwd, mdcc_pkg::DirBwd, mdcc_pkg::DirBwd},
        '{mdcc_pkg::DirFwd, mdcc_pkg::DirBwd, mdcc_pkg::DirFwd, mdcc_pkg::DirBwd},
        '{mdcc_pkg::DirBwd, mdcc_pkg::DirFwd, mdcc_pkg::DirBwd, mdcc_pkg::DirFwd},
        '{mdcc_pkg::DirFwd, mdcc_pkg::DirRel, mdcc_pkg::DirFwd, mdcc_pkg::DirRel},
        '{mdcc_pkg::DirRel, mdcc_pkg::DirFwd, mdcc_pkg::DirRel, mdcc_pkg::DirFwd},
        '{mdcc_pkg::DirBwd, mdcc_pkg::DirRel, mdcc_pkg::DirBwd, mdcc_pkg::DirRel},
        '{mdcc_pkg::DirRel, mdcc_pkg::DirBwd, mdcc_pkg::DirRel, mdcc_pkg::DirBwd},
        '{mdcc_pkg::DirRel, mdcc_pkg::DirBwd, mdcc_pkg::DirBwd, mdcc_pkg::DirRel},
        '{mdcc_pkg::DirRel, mdcc_pkg::DirFwd, mdcc_pkg::DirFwd, mdcc_pkg::DirRel},
        '{mdcc_pkg::DirBwd, mdcc_pkg::DirRel, mdcc_pkg::DirRel, mdcc_pkg::DirBwd},
        '{mdcc_pkg::DirFwd, mdcc_pkg::DirRel, mdcc_pkg::DirRel, mdcc_pkg::DirFwd},
        '{mdcc_pkg::DirFwd, mdcc_pkg::DirBwd, mdcc_pkg::DirRel, mdcc_pkg::DirRel},
        '{mdcc_pkg::DirRel, mdcc_pkg::DirRel, mdcc_pkg::DirBwd, mdcc_pkg::DirFwd},
        '{mdcc_pkg::DirRel, mdcc_pkg::DirFwd, mdcc_pkg::DirRel, mdcc_pkg::DirBwd},
        '{mdcc_pkg::DirFwd, mdcc_pkg::DirRel, mdcc_pkg::DirBwd, mdcc_pkg::DirRel},
        '{mdcc_pkg::DirFwd, mdcc_pkg::DirBwd, mdcc_pkg::DirBwd, mdcc_pkg::DirFwd},
        '{mdcc_pkg::DirBwd, mdcc_pkg::DirFwd, mdcc_pkg::DirFwd, mdcc_pkg::DirBwd}
      };
      max_speed    = mdcc_pkg::MaxSpeedRst;
      max_dur_ms   = mdcc_pkg::MaxDurRst;
      timeout_ms   = mdcc_pkg::TimeoutRst;
      auto_mode    = 1'b0;
      idle_ms      = '0;
      last_code    = mdcc_pkg::MoveStop;
      errors       = 0;
      results_seen = 0;
      release_wheels();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        mdcc_pkg::RegMaxSpeed: max_speed  = value[7:0];
        mdcc_pkg::RegMaxDur:   max_dur_ms = value[15:0];
        mdcc_pkg::RegTimeout:  timeout_ms = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        mdcc_pkg::RegMaxSpeed: return {24'd0, max_speed};
        mdcc_pkg::RegMaxDur:   return {16'd0, max_dur_ms};
        default:               return {16'd0, timeout_ms};
      endcase
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void release_wheels();
      foreach (dirs[i]) dirs[i] = mdcc_pkg::DirRel;
      speed_held   = '0;
      remaining_ms = '0;
    endfunction

    function void enter_mode(bit autonomous);
      if (autonomous != auto_mode) begin
        auto_mode = autonomous;
        last_code = mdcc_pkg::MoveStop;
        release_wheels();
      end
    endfunction

    // negative requests go to zero, others saturate at the limit
    function logic [15:0] clamp_request(logic [16:0] raw, logic [15:0] limit);
      if (raw[16]) return '0;
      if (raw > {1'b0, limit}) return limit;
      return raw[15:0];
    endfunction

    function void note_input(bit is_tick, logic [4:0] code, logic [15:0] sp_raw,
                             logic [16:0] du_raw);
      logic [15:0]   sp;
      logic [15:0]   du;
      drive_status_t st;
      if (!is_tick) begin
        idle_ms = '0;
        if (code == mdcc_pkg::MoveResume) begin
          enter_mode(1'b1);
        end else begin
          enter_mode(1'b0);
          if (code >= mdcc_pkg::TableSize) begin
            last_code = mdcc_pkg::MoveStop;
            release_wheels();
          end else begin
            sp = clamp_request({sp_raw[15], sp_raw}, {8'd0, max_speed});
            du = clamp_request(du_raw, max_dur_ms);
            last_code = code;
            if (code == mdcc_pkg::MoveStop || sp == 0 || du == 0) begin
              release_wheels();
            end else begin
              dirs         = wheel_map[code];
              speed_held   = sp[7:0];
              remaining_ms = du;
            end
          end
        end
      end else begin
        if (remaining_ms != 0) begin
          remaining_ms--;
          if (remaining_ms == 0) release_wheels();
        end
        if (idle_ms != 16'hFFFF) idle_ms++;
        // deadman: manual mode only, and only while a move runs
        if (!auto_mode && idle_ms > timeout_ms && remaining_ms != 0) release_wheels();
      end
      st.front_left    = dirs[0];
      st.front_right   = dirs[1];
      st.rear_right    = dirs[2];
      st.rear_left     = dirs[3];
      st.drive_speed   = speed_held;
      st.moving        = (remaining_ms != 0);
      st.autonomous    = auto_mode;
      st.reported_move = last_code;
      status_q.push_back(st);
    endfunction

    task check_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", results_seen, field, got, want));
    endtask

    task check_status(logic [23:0] raw);
      drive_status_t got;
      drive_status_t want;
      results_seen++;
      if (status_q.size() == 0) begin
        report($sformatf("result %0d arrived with none pending", results_seen));
        return;
      end
      want = status_q.pop_front();
      got  = raw[22:0];
      check_field("dir_front_left", 8'(got.front_left), 8'(want.front_left));
      check_field("dir_front_right", 8'(got.front_right), 8'(want.front_right));
      check_field("dir_rear_right", 8'(got.rear_right), 8'(want.rear_right));
      check_field("dir_rear_left", 8'(got.rear_left), 8'(want.rear_left));
      check_field("drive_speed", got.drive_speed, want.drive_speed);
      check_field("moving", 8'(got.moving), 8'(want.moving));
      check_field("autonomous", 8'(got.autonomous), 8'(want.autonomous));
      check_field("reported_move", 8'(got.reported_move), 8'(want.reported_move));
      check_field("pad", 8'(raw[23]), 8'd0);
    endtask
  endclass

  drive_scoreboard sb = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  task automatic apb_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    sb.set_reg(idx, value);
  endtask

  task automatic check_registers();
    logic [1:0]  regs [3];
    logic [31:0] rdata;
    regs = '{mdcc_pkg::RegMaxSpeed, mdcc_pkg::RegMaxDur, mdcc_pkg::RegTimeout};
    foreach (regs[i]) begin
      apb_access(1'b0, regs[i], '0, rdata);
      if (rdata !== sb.reg_value(regs[i]))
        sb.report($sformatf("register %0d read %0h want %0h", regs[i], rdata,
                            sb.reg_value(regs[i])));
    end
  endtask

  // one input transaction, then a random gap unless tx_steady is set
  task automatic issue(bit is_tick, logic [4:0] code, logic [15:0] sp, logic [16:0] du);
    int n;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= is_tick;
    s_axis_tdata  <= {2'b00, du, sp, code};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(is_tick, code, sp, du);
    n = tx_steady ? 0 : gap_length();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic random_item();
    int          pick;
    logic [4:0]  code;
    logic [15:0] sp;
    logic [16:0] du;
    pick = $urandom_range(0, 99);
    code = 5'($urandom_range(0, mdcc_pkg::TableSize - 1));
    sp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    case ($urandom_range(0, 4))
      0:       du = 17'($urandom);
      1:       du = 17'($urandom_range(0, 65535));
      default: du = 17'($urandom_range(0, 40));
    endcase
    if (pick < 50) issue(1'b1, code, sp, du);
    else if (pick < 88) issue(1'b0, code, sp, du);
    else if (pick < 94) issue(1'b0, mdcc_pkg::MoveResume, sp, du);
    else issue(1'b0, 5'($urandom), sp, du);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    repeat (3) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int stall;
    int span;
    int served;
    bit steady;
    stall  = 0;
    span   = 0;
    served = 0;
    steady = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
      if (holds_asked != served) begin
        // long back-pressure so the input side fills up and stalls
        served++;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (span == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        span   = $urandom_range(100, 400);
      end
      span--;
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady) stall = gap_length();
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_registers();

    issue(1'b1, 5'($urandom), 16'($urandom), 17'($urandom));
    issue(1'b0, MoveForward, 16'd100, 17'd3);
    repeat (3) issue(1'b1, 5'($urandom), 16'($urandom), 17'($urandom));
    issue(1'b0, MoveLast, 16'h7FFF, 17'h0FFFF);
    issue(1'b0, MoveTurnRight, 16'h8000, 17'd50);
    issue(1'b0, MoveTurnLeft, 16'd80, 17'h1FFFF);
    issue(1'b0, MoveBackward, 16'd0, 17'd10);
    issue(1'b0, MoveTurnRight, 16'd60, 17'd0);
    issue(1'b0, MoveBackward, 16'd90, 17'd20);
    issue(1'b0, mdcc_pkg::MoveStop, 16'd200, 17'd200);
    issue(1'b0, MoveTurnLeft, 16'hFFFF, 17'd20);
    issue(1'b0, MoveUnknownHi, 16'd50, 17'd20);
    issue(1'b0, MoveForward, 16'd1, 17'd1);
    issue(1'b0, MoveUnknownLo, 16'd50, 17'd20);
    issue(1'b0, MoveLast, 16'd40, 17'd100);
    issue(1'b0, mdcc_pkg::MoveResume, 16'd40, 17'd100);
    issue(1'b0, mdcc_pkg::MoveResume, 16'd40, 17'd100);
    issue(1'b1, 5'($urandom), 16'($urandom), 17'($urandom));
    issue(1'b0, MoveTurnLeft, 16'd70, 17'd5);
    repeat (2) issue(1'b1, 5'($urandom), 16'($urandom), 17'($urandom));

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      reg_write(mdcc_pkg::RegMaxSpeed, {24'($urandom), 8'(phase_speed[phase])});
      reg_write(mdcc_pkg::RegMaxDur, {16'($urandom), 16'(phase_dur[phase])});
      reg_write(mdcc_pkg::RegTimeout, {16'($urandom), 16'(phase_timeout[phase])});
      reg_write(RegUnused, $urandom);
      check_registers();
      tx_steady = (phase == HoldPhase) || ($urandom_range(0, 3) == 0);
      for (int item = 0; item < ItemsPerPhase; item++) begin
        if (phase == HoldPhase && item == 40) holds_asked <= holds_asked + 1;
        if ($urandom_range(0, 99) == 0) drain();
        random_item();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
